// ===== design/cwl_pkg.sv =====
// Shared types, widths and preset window tables for the CT window/level gray mapper.
package cwl_pkg;

  // field and datapath widths
  localparam int HU_W    = 16;  // input sample
  localparam int WID_W   = 16;  // window width / centre registers
  localparam int PRE_W   = 3;   // preset selector
  localparam int IDX_W   = 2;   // config register index
  localparam int GRAY_W  = 8;   // output gray level
  localparam int DIFF_W  = HU_W + 1;   // hu - centre, signed
  localparam int DEN_W   = WID_W + 1;  // 2 * width
  localparam int NUM_W   = 27;  // 510*d + 256*w, signed
  localparam int REM_W   = NUM_W - 1;  // numerator once known non-negative

  // quotient bits resolved per pipeline stage
  localparam int QBITS_PER_STAGE = 2;
  localparam int DIV_STAGES      = GRAY_W / QBITS_PER_STAGE;

  // config register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_CENTRE = 2'd1,
    REG_INVERT = 2'd2,
    REG_PRESET = 2'd3
  } cfg_reg_t;

  // preset codes
  localparam logic [PRE_W-1:0] PRESET_EXPLICIT = 3'd0;
  localparam logic [PRE_W-1:0] PRESET_LUNG     = 3'd1;
  localparam logic [PRE_W-1:0] PRESET_BONE     = 3'd2;
  localparam logic [PRE_W-1:0] PRESET_BRAIN    = 3'd3;
  localparam logic [PRE_W-1:0] PRESET_ABDOMEN  = 3'd4;
  localparam logic [PRE_W-1:0] PRESET_ANGIO    = 3'd5;
  localparam logic [PRE_W-1:0] PRESET_SPINE    = 3'd6;
  localparam logic [PRE_W-1:0] PRESET_SOFT     = 3'd7;

  // one request in flight between pipeline stages
  typedef struct packed {
    logic [REM_W-1:0]  rem;   // running remainder
    logic [DEN_W-1:0]  den;   // 2 * effective width
    logic [GRAY_W-1:0] quo;   // quotient bits resolved so far
    logic              neg;   // numerator below zero: gray is 0
    logic              last;  // frame end marker
  } cwl_word_t;

  // preset window width
  function automatic logic [WID_W-1:0] preset_width(input logic [PRE_W-1:0] sel);
    logic [WID_W-1:0] w;
    unique case (sel)
      PRESET_LUNG:    w = 16'd1500;
      PRESET_BONE:    w = 16'd2500;
      PRESET_BRAIN:   w = 16'd80;
      PRESET_ABDOMEN: w = 16'd400;
      PRESET_ANGIO:   w = 16'd600;
      PRESET_SPINE:   w = 16'd250;
      PRESET_SOFT:    w = 16'd350;
      default:        w = 16'd400;
    endcase
    return w;
  endfunction

  // preset window centre
  function automatic logic signed [WID_W-1:0] preset_centre(input logic [PRE_W-1:0] sel);
    logic signed [WID_W-1:0] c;
    unique case (sel)
      PRESET_LUNG:    c = -16'sd500;
      PRESET_BONE:    c = 16'sd500;
      PRESET_BRAIN:   c = 16'sd40;
      PRESET_ABDOMEN: c = 16'sd40;
      PRESET_ANGIO:   c = 16'sd300;
      PRESET_SPINE:   c = 16'sd50;
      PRESET_SOFT:    c = 16'sd50;
      default:        c = 16'sd40;
    endcase
    return c;
  endfunction

endpackage

// ===== design/cwl_front.sv =====
// First pipeline stage: window selection and numerator 510*d + 256*w.
module cwl_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  output logic                                in_rdy,
  input  logic signed [cwl_pkg::HU_W-1:0]     hu,
  input  logic                                last,
  input  logic [cwl_pkg::WID_W-1:0]           cfg_width,
  input  logic signed [cwl_pkg::WID_W-1:0]    cfg_centre,
  input  logic                                cfg_invert,
  input  logic [cwl_pkg::PRE_W-1:0]           cfg_preset,
  output logic                                out_vld,
  input  logic                                out_rdy,
  output cwl_pkg::cwl_word_t                  out_word
);
  import cwl_pkg::*;

  logic [WID_W-1:0]         w_sel;
  logic signed [WID_W-1:0]  c_sel;
  logic [WID_W-1:0]         w_eff;
  logic signed [DIFF_W-1:0] diff;
  logic signed [NUM_W-1:0]  num;
  cwl_word_t                word_nxt;
  cwl_word_t                word_r;
  logic                     vld_r;

  // pick window, zero width counts as one
  always_comb begin
    if (cfg_preset == PRESET_EXPLICIT) begin
      w_sel = cfg_width;
      c_sel = cfg_centre;
    end else begin
      w_sel = preset_width(cfg_preset);
      c_sel = preset_centre(cfg_preset);
    end
    w_eff = (w_sel == '0) ? WID_W'(1) : w_sel;
  end

  // signed distance from centre and numerator over denominator 2w
  always_comb begin
    if (cfg_invert) begin
      diff = DIFF_W'(c_sel) - DIFF_W'(hu);
    end else begin
      diff = DIFF_W'(hu) - DIFF_W'(c_sel);
    end
    num = (NUM_W'(diff) <<< 9) - (NUM_W'(diff) <<< 1)
        + $signed({{(NUM_W-WID_W-8){1'b0}}, w_eff, 8'd0});
    word_nxt.neg  = num[NUM_W-1];
    word_nxt.rem  = num[NUM_W-1] ? '0 : num[REM_W-1:0];
    word_nxt.den  = {w_eff, 1'b0};
    word_nxt.quo  = '0;
    word_nxt.last = last;
  end

  assign in_rdy   = !vld_r || out_rdy;
  assign out_vld  = vld_r;
  assign out_word = word_r;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      word_r <= word_nxt;
    end
  end

endmodule

// ===== design/cwl_div_step.sv =====
// Restoring divider stage: resolves QBITS_PER_STAGE quotient bits per register stage.
module cwl_div_step #(
  parameter int STAGE = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  output logic               in_rdy,
  input  cwl_pkg::cwl_word_t in_word,
  output logic               out_vld,
  input  logic               out_rdy,
  output cwl_pkg::cwl_word_t out_word
);
  import cwl_pkg::*;

  localparam int HI = GRAY_W - 1 - STAGE * QBITS_PER_STAGE;

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] shifted;
  logic [GRAY_W-1:0] quo;
  cwl_word_t        word_nxt;
  cwl_word_t        word_r;
  logic             vld_r;

  // trial subtract of den shifted to each bit position
  always_comb begin
    rem = in_word.rem;
    quo = in_word.quo;
    shifted = '0;
    for (int i = 0; i < QBITS_PER_STAGE; i++) begin
      shifted = REM_W'(in_word.den) << (HI - i);
      if (rem >= shifted) begin
        rem = rem - shifted;
        quo[HI - i] = 1'b1;
      end
    end
    word_nxt      = in_word;
    word_nxt.rem  = rem;
    word_nxt.quo  = quo;
  end

  assign in_rdy   = !vld_r || out_rdy;
  assign out_vld  = vld_r;
  assign out_word = word_r;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      word_r <= word_nxt;
    end
  end

endmodule

// ===== design/ct_window_level_gray_map.sv =====
// Top level of the CT window/level gray mapper: config registers, pipeline and output stage.
//
//  Channel | Ports                          | Carries
//  --------+--------------------------------+-------------------------------------------
//  input   | in_tvalid/in_tready/in_tdata   | tdata[15:0] hu_value, tlast last_pixel
//  output  | out_tvalid/out_tready/out_tdata| tdata[7:0] gray_level, tlast frame_end
//  config  | cfg_we/cfg_index/cfg_wdata     | width, centre, invert, preset by index
//
//  One request per cycle sustained while out_tready holds; the registers are the window/numerator stage,
//  four divider stages at two quotient bits each, and the clamp/output register.
//  Reset (rst_n low, synchronous) empties the pipeline and loads the default window.
//  Each stage holds its request while the stage after it is full and stalled; bubbles
//  close up, so input is taken whenever any stage ahead can move.
module ct_window_level_gray_map (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [15:0]                  in_tdata,   // [15:0] hu_value
  input  logic                         in_tlast,   // last_pixel
  // output stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // [7:0] gray_level
  output logic                         out_tlast,  // frame_end
  // config write port
  input  logic                         cfg_we,
  input  logic [cwl_pkg::IDX_W-1:0]    cfg_index,
  input  logic [cwl_pkg::WID_W-1:0]    cfg_wdata
);
  import cwl_pkg::*;

  logic [WID_W-1:0]        width_r;
  logic signed [WID_W-1:0] centre_r;
  logic                    invert_r;
  logic [PRE_W-1:0]        preset_r;

  cwl_word_t stg_word [DIV_STAGES+1];
  logic      stg_vld  [DIV_STAGES+1];
  logic      stg_rdy  [DIV_STAGES+1];

  logic              out_vld_r;
  logic [GRAY_W-1:0] gray_r;
  logic              last_r;
  logic [GRAY_W-1:0] gray_nxt;
  logic              sat;
  logic              out_adv;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WID_W'(400);
      centre_r <= WID_W'(40);
      invert_r <= 1'b0;
      preset_r <= PRESET_EXPLICIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_CENTRE: centre_r <= $signed(cfg_wdata);
        REG_INVERT: invert_r <= cfg_wdata[0];
        REG_PRESET: preset_r <= cfg_wdata[PRE_W-1:0];
      endcase
    end
  end

  // window and numerator
  cwl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (in_tvalid),
    .in_rdy     (in_tready),
    .hu         ($signed(in_tdata)),
    .last       (in_tlast),
    .cfg_width  (width_r),
    .cfg_centre (centre_r),
    .cfg_invert (invert_r),
    .cfg_preset (preset_r),
    .out_vld    (stg_vld[0]),
    .out_rdy    (stg_rdy[0]),
    .out_word   (stg_word[0])
  );

  // divider pipeline
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    cwl_div_step #(.STAGE(s)) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (stg_vld[s]),
      .in_rdy   (stg_rdy[s]),
      .in_word  (stg_word[s]),
      .out_vld  (stg_vld[s+1]),
      .out_rdy  (stg_rdy[s+1]),
      .out_word (stg_word[s+1])
    );
  end

  // clamp: negative gives 0, remainder still >= den means quotient overflowed 255
  always_comb begin
    sat = stg_word[DIV_STAGES].rem >= REM_W'(stg_word[DIV_STAGES].den);
    if (stg_word[DIV_STAGES].neg) begin
      gray_nxt = '0;
    end else if (sat) begin
      gray_nxt = '1;
    end else begin
      gray_nxt = stg_word[DIV_STAGES].quo;
    end
  end

  assign out_adv              = !out_vld_r || out_tready;
  assign stg_rdy[DIV_STAGES]  = out_adv;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= stg_vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && stg_vld[DIV_STAGES]) begin
      gray_r <= gray_nxt;
      last_r <= stg_word[DIV_STAGES].last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = gray_r;
  assign out_tlast  = last_r;

endmodule

// ===== design/cwl_checker.sv =====
// Port-level checker for the CT window/level gray mapper, bound to the top level.
module cwl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // an empty or draining output side never blocks the input
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled while pipeline can move");

  // with the sink always ready, a request passes the front, divider and output registers and comes out
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready ##1 out_tready
      ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("request lost in pipeline");

endmodule

bind ct_window_level_gray_map cwl_checker u_cwl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
